### design/bmig_pkg.sv
// ----------------------------------------------------------------------------
// bmig_pkg
// Shared types and codes of the bank mapper and I/O glue block.
// ----------------------------------------------------------------------------
package bmig_pkg;

  localparam logic [2:0] OP_MEM_RD = 3'd0;
  localparam logic [2:0] OP_MEM_WR = 3'd1;
  localparam logic [2:0] OP_IO_RD  = 3'd2;
  localparam logic [2:0] OP_IO_WR  = 3'd3;
  localparam logic [2:0] OP_TICK   = 3'd4;

  localparam logic [1:0] TGT_ROM  = 2'd0;
  localparam logic [1:0] TGT_RAM  = 2'd1;
  localparam logic [1:0] TGT_CARD = 2'd2;
  localparam logic [1:0] TGT_NONE = 2'd3;

  localparam logic [1:0] SEL_ROM  = 2'b00;
  localparam logic [1:0] SEL_RAM  = 2'b01;
  localparam logic [1:0] SEL_CARD = 2'b10;
  localparam logic [1:0] SEL_NONE = 2'b11;

  localparam logic [3:0] DEV_VIDEO  = 4'h0;
  localparam logic [3:0] DEV_BANK   = 4'h1;
  localparam logic [3:0] DEV_MISC   = 4'h3;
  localparam logic [3:0] DEV_PRINT  = 4'h4;
  localparam logic [3:0] DEV_IRQ_EN = 4'h6;
  localparam logic [3:0] DEV_POWER  = 4'h7;
  localparam logic [3:0] DEV_IRQ_ST = 4'h9;
  localparam logic [3:0] DEV_CARD   = 4'hA;
  localparam logic [3:0] DEV_KEYS   = 4'hB;
  localparam logic [3:0] DEV_UART   = 4'hC;

  localparam logic [3:0] KEY_LAST_ROW = 4'd9;

  localparam logic [1:0] CFG_ROM_MASK  = 2'd0;
  localparam logic [1:0] CFG_RAM_MASK  = 2'd1;
  localparam logic [1:0] CFG_CARD_SIZE = 2'd2;

  localparam logic [4:0]  ROM_MASK_RST  = 5'd15;
  localparam logic [2:0]  RAM_MASK_RST  = 3'd3;
  localparam logic [20:0] CARD_SIZE_RST = 21'd0;

  localparam logic [7:0] IRQ_STATUS_RST = 8'h0F;
  localparam logic [7:0] IRQ_KEY_BIT    = 8'h08;
  localparam logic [7:0] IRQ_MISC_BIT   = 8'h04;
  localparam logic [7:0] CARD_PRESENT   = 8'h20;
  localparam logic [7:0] CARD_ABSENT    = 8'hA0;
  localparam logic [7:0] BUS_IDLE       = 8'hFF;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [7:0]  key_sense;
  } bmig_in_t;

  typedef struct packed {
    logic [1:0]  target;
    logic [19:0] phys_addr;
    logic [7:0]  read_data;
    logic        int_request;
    logic        power_off;
    logic [3:0]  video_base;
    logic [7:0]  printer_data;
  } bmig_out_t;

  typedef struct packed {
    logic [4:0]  rom_bank_mask;
    logic [2:0]  ram_bank_mask;
    logic [20:0] card_size;
  } bmig_cfg_t;

  typedef struct packed {
    logic       int_request;
    logic       power_off;
    logic [3:0] video_base;
    logic [7:0] printer_data;
  } bmig_stat_t;

endpackage

### design/bmig_xlate.sv
// ----------------------------------------------------------------------------
// bmig_xlate
// Translates a CPU memory address through the selected bank register to a
// target region and a byte offset within it.
// ----------------------------------------------------------------------------
module bmig_xlate (
  input  logic              is_mem,
  input  logic              is_wr,
  input  logic [7:0]        bank,
  input  logic [13:0]       offset,
  input  logic              card_en,
  input  bmig_pkg::bmig_cfg_t cfg,
  output logic [1:0]        target,
  output logic [19:0]       phys_addr
);

  logic [19:0] card_addr;

  assign card_addr = {bank[5:0], offset};

  always_comb begin
    target    = bmig_pkg::TGT_NONE;
    phys_addr = 20'd0;
    if (is_mem) begin
      unique case (bank[7:6])
        bmig_pkg::SEL_ROM: begin
          if (!is_wr) begin
            target    = bmig_pkg::TGT_ROM;
            phys_addr = {1'b0, bank[4:0] & cfg.rom_bank_mask, offset};
          end
        end
        bmig_pkg::SEL_RAM: begin
          target    = bmig_pkg::TGT_RAM;
          phys_addr = {3'd0, bank[2:0] & cfg.ram_bank_mask, offset};
        end
        bmig_pkg::SEL_CARD: begin
          if (cfg.card_size != 21'd0 && card_en && {1'b0, card_addr} < cfg.card_size) begin
            target    = bmig_pkg::TGT_CARD;
            phys_addr = card_addr;
          end
        end
        bmig_pkg::SEL_NONE: begin
          target = bmig_pkg::TGT_NONE;
        end
        default: begin
          target = bmig_pkg::TGT_NONE;
        end
      endcase
    end
  end

endmodule

### design/bmig_io.sv
// ----------------------------------------------------------------------------
// bmig_io
// I/O register file: bank, interrupt, misc, video, printer and power
// registers, with port decode for reads and writes and the tick effect.
// ----------------------------------------------------------------------------
module bmig_io (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  bmig_pkg::bmig_in_t   item,
  input  logic [20:0]          card_size,
  output logic [7:0]           bank_sel,
  output logic                 card_en,
  output logic [7:0]           read_data,
  output bmig_pkg::bmig_stat_t stat
);

  logic [3:0][7:0] bank_r, bank_nxt;
  logic [7:0]      irq_status_r, irq_status_nxt;
  logic [3:0]      irq_enable_r, irq_enable_nxt;
  logic [1:0]      misc_r, misc_nxt;
  logic [3:0]      display_r, display_nxt;
  logic [7:0]      printer_r, printer_nxt;
  logic            power_r, power_nxt;

  logic [7:0] port;
  logic [3:0] dev;
  logic [1:0] bank_idx;
  logic       is_io;

  assign port     = item.addr[7:0];
  assign dev      = port[7:4];
  assign is_io    = (item.op == bmig_pkg::OP_IO_RD) || (item.op == bmig_pkg::OP_IO_WR);
  assign bank_idx = is_io ? port[1:0] : item.addr[15:14];
  assign bank_sel = bank_r[bank_idx];
  assign card_en  = misc_r[1];

  always_comb begin
    bank_nxt       = bank_r;
    irq_status_nxt = irq_status_r;
    irq_enable_nxt = irq_enable_r;
    misc_nxt       = misc_r;
    display_nxt    = display_r;
    printer_nxt    = printer_r;
    power_nxt      = power_r;
    read_data      = bmig_pkg::BUS_IDLE;
    if (item.op == bmig_pkg::OP_IO_RD) begin
      unique case (dev)
        bmig_pkg::DEV_BANK:   read_data = bank_sel;
        bmig_pkg::DEV_IRQ_ST: read_data = irq_status_r;
        bmig_pkg::DEV_CARD: begin
          read_data = (card_size == 21'd0) ? bmig_pkg::CARD_ABSENT : bmig_pkg::CARD_PRESENT;
        end
        bmig_pkg::DEV_KEYS: begin
          if (port[3:0] == bmig_pkg::KEY_LAST_ROW) begin
            irq_status_nxt = irq_status_r | bmig_pkg::IRQ_KEY_BIT;
          end
          read_data = (port[3:0] <= bmig_pkg::KEY_LAST_ROW) ? item.key_sense
                                                            : bmig_pkg::BUS_IDLE;
        end
        bmig_pkg::DEV_UART:   read_data = {7'd0, port[0]};
        default:              read_data = bmig_pkg::BUS_IDLE;
      endcase
    end else if (item.op == bmig_pkg::OP_IO_WR) begin
      unique case (dev)
        bmig_pkg::DEV_VIDEO:  display_nxt = item.wdata[7:4];
        bmig_pkg::DEV_BANK:   bank_nxt[port[1:0]] = item.wdata;
        bmig_pkg::DEV_MISC: begin
          if (misc_r[0] && !item.wdata[6]) begin
            irq_status_nxt = irq_status_r & ~bmig_pkg::IRQ_MISC_BIT;
          end
          misc_nxt = item.wdata[7:6];
        end
        bmig_pkg::DEV_PRINT:  printer_nxt = item.wdata;
        bmig_pkg::DEV_IRQ_EN: irq_enable_nxt = item.wdata[3:0];
        bmig_pkg::DEV_POWER: begin
          if (!item.wdata[0]) begin
            power_nxt = 1'b1;
          end
        end
        bmig_pkg::DEV_IRQ_ST: irq_status_nxt = irq_status_r | ~item.wdata;
        default:              power_nxt = power_r;
      endcase
    end else if (item.op == bmig_pkg::OP_TICK) begin
      irq_status_nxt = irq_status_r & ~bmig_pkg::IRQ_KEY_BIT;
    end
  end

  assign stat.int_request  = |(~irq_status_nxt[3:0] & irq_enable_nxt);
  assign stat.power_off    = power_nxt;
  assign stat.video_base   = display_nxt;
  assign stat.printer_data = printer_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r       <= '0;
      irq_status_r <= bmig_pkg::IRQ_STATUS_RST;
      irq_enable_r <= 4'd0;
      misc_r       <= 2'b11;
      display_r    <= 4'd0;
      printer_r    <= 8'd0;
      power_r      <= 1'b0;
    end else if (fire) begin
      bank_r       <= bank_nxt;
      irq_status_r <= irq_status_nxt;
      irq_enable_r <= irq_enable_nxt;
      misc_r       <= misc_nxt;
      display_r    <= display_nxt;
      printer_r    <= printer_nxt;
      power_r      <= power_nxt;
    end
  end

  a_power_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    power_r |=> power_r)
    else $error("power down state was released without reset");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(irq_status_r) && $stable(bank_r))
    else $error("register file changed without a transaction");

endmodule

### design/bank_mapper_io_glue.sv
// An accepted transaction goes into the input register, then the result register.
// Throughput: one transaction per cycle when not stalled by out_ready; the
// input register drains into the result one whenever that is empty or being taken.
// Reset (synchronous, rst_n low) clears both stages and loads the reset values
// of the configuration and I/O registers; there is no clearing pass.
// ----------------------------------------------------------------------------
// bank_mapper_io_glue
// System glue: bank translation of memory accesses, I/O port registers and
// timer tick handling, with an input register and a result register.
// ----------------------------------------------------------------------------
module bank_mapper_io_glue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bmig_pkg::bmig_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bmig_pkg::bmig_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [20:0]         cfg_data
);

  logic                 s1_valid_r;
  bmig_pkg::bmig_in_t   s1_data_r;
  logic                 out_valid_r;
  bmig_pkg::bmig_out_t  out_data_r, out_data_nxt;
  bmig_pkg::bmig_cfg_t  cfg_r;
  logic                 s1_adv;
  logic [7:0]           bank_sel;
  logic                 card_en;
  logic [7:0]           read_data;
  bmig_pkg::bmig_stat_t stat;
  logic [1:0]           target;
  logic [19:0]          phys_addr;
  logic                 is_mem;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign cfg_ready = 1'b1;
  assign is_mem    = (s1_data_r.op == bmig_pkg::OP_MEM_RD) ||
                     (s1_data_r.op == bmig_pkg::OP_MEM_WR);

  bmig_io u_io (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (s1_adv),
    .item      (s1_data_r),
    .card_size (cfg_r.card_size),
    .bank_sel  (bank_sel),
    .card_en   (card_en),
    .read_data (read_data),
    .stat      (stat)
  );

  bmig_xlate u_xlate (
    .is_mem    (is_mem),
    .is_wr     (s1_data_r.op == bmig_pkg::OP_MEM_WR),
    .bank      (bank_sel),
    .offset    (s1_data_r.addr[13:0]),
    .card_en   (card_en),
    .cfg       (cfg_r),
    .target    (target),
    .phys_addr (phys_addr)
  );

  always_comb begin
    out_data_nxt.target       = target;
    out_data_nxt.phys_addr    = phys_addr;
    out_data_nxt.read_data    = read_data;
    out_data_nxt.int_request  = stat.int_request;
    out_data_nxt.power_off    = stat.power_off;
    out_data_nxt.video_base   = stat.video_base;
    out_data_nxt.printer_data = stat.printer_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rom_bank_mask <= bmig_pkg::ROM_MASK_RST;
      cfg_r.ram_bank_mask <= bmig_pkg::RAM_MASK_RST;
      cfg_r.card_size     <= bmig_pkg::CARD_SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bmig_pkg::CFG_ROM_MASK:  cfg_r.rom_bank_mask <= cfg_data[4:0];
        bmig_pkg::CFG_RAM_MASK:  cfg_r.ram_bank_mask <= cfg_data[2:0];
        bmig_pkg::CFG_CARD_SIZE: cfg_r.card_size     <= cfg_data;
        default:                 cfg_r.card_size     <= cfg_r.card_size;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> s1_valid_r)
    else $error("accepted transaction did not reach the input register");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_data_r))
    else $error("stalled input register lost or changed its transaction");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.target == bmig_pkg::TGT_NONE |-> out_data_r.phys_addr == 20'd0)
    else $error("offset is not zero for an untargeted result");

  a_adv_fills: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("result register not loaded after the input register drained");

endmodule

### tb/bank_mapper_io_glue_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bank_mapper_io_glue_test
// Self-checking bench for the glue block. Bus transactions go in over a
// valid/ready channel. A predictor inside the bench follows the bank
// registers, the port registers and the three configuration registers, and
// works out the expected result of every accepted transaction. Each returned
// result is compared field by field with the oldest expected one. The run has
// directed port and bank checks first, then random traffic under three
// idling patterns, with register changes between chunks.
// ----------------------------------------------------------------------------
module bank_mapper_io_glue_test;

  localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;
  localparam logic [3:0] DEV_CLOCK       = 4'hD;

  logic                logic_unused_guard;
  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  bmig_pkg::bmig_in_t  in_data;
  logic                out_valid;
  logic                out_ready = 1'b0;
  bmig_pkg::bmig_out_t out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [1:0]          cfg_index;
  logic [20:0]         cfg_data;

  logic [7:0]  bank_sel [4];
  logic [7:0]  irq_status;
  logic [7:0]  irq_enable;
  logic [7:0]  misc_ctrl;
  logic [3:0]  video_page;
  logic [7:0]  print_latch;
  logic        powered_down;
  logic [4:0]  rom_bank_bits;
  logic [2:0]  ram_bank_bits;
  logic [20:0] card_bytes;

  bmig_pkg::bmig_out_t expected_results [$];
  int unsigned mismatches = 0;
  int unsigned accesses_sent = 0;
  int unsigned results_checked = 0;
  int unsigned reg_writes = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  bank_mapper_io_glue DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic bmig_pkg::bmig_out_t glue_predict(bmig_pkg::bmig_in_t it);
    bmig_pkg::bmig_out_t r;
    logic [7:0]  bank;
    logic [7:0]  port;
    logic [31:0] off;
    logic [31:0] span;
    r = '0;
    r.target = bmig_pkg::TGT_NONE;
    r.read_data = bmig_pkg::BUS_IDLE;
    bank = bank_sel[it.addr[15:14]];
    off = 32'(it.addr[13:0]);
    port = it.addr[7:0];
    case (it.op)
      bmig_pkg::OP_MEM_RD, bmig_pkg::OP_MEM_WR: begin
        case (bank[7:6])
          bmig_pkg::SEL_ROM: begin
            if (it.op == bmig_pkg::OP_MEM_RD) begin
              span = 32'(bank & {3'b000, rom_bank_bits});
              r.target = bmig_pkg::TGT_ROM;
              r.phys_addr = 20'((span << 14) + off);
            end
          end
          bmig_pkg::SEL_RAM: begin
            span = 32'(bank & {5'b00000, ram_bank_bits});
            r.target = bmig_pkg::TGT_RAM;
            r.phys_addr = 20'((span << 14) + off);
          end
          bmig_pkg::SEL_CARD: begin
            span = (32'(bank[5:0]) << 14) + off;
            if (card_bytes != '0 && misc_ctrl[7] && span < 32'(card_bytes)) begin
              r.target = bmig_pkg::TGT_CARD;
              r.phys_addr = span[19:0];
            end
          end
          default: ;
        endcase
      end
      bmig_pkg::OP_IO_RD: begin
        case (port[7:4])
          bmig_pkg::DEV_BANK:   r.read_data = bank_sel[port[1:0]];
          bmig_pkg::DEV_IRQ_ST: r.read_data = irq_status;
          bmig_pkg::DEV_CARD: begin
            r.read_data = (card_bytes == '0) ? bmig_pkg::CARD_ABSENT
                                             : bmig_pkg::CARD_PRESENT;
          end
          bmig_pkg::DEV_KEYS: begin
            if (port[3:0] == bmig_pkg::KEY_LAST_ROW) irq_status |= bmig_pkg::IRQ_KEY_BIT;
            r.read_data = (port[3:0] <= bmig_pkg::KEY_LAST_ROW) ? it.key_sense
                                                                : bmig_pkg::BUS_IDLE;
          end
          bmig_pkg::DEV_UART:   r.read_data = {7'd0, port[0]};
          default: ;
        endcase
      end
      bmig_pkg::OP_IO_WR: begin
        case (port[7:4])
          bmig_pkg::DEV_VIDEO:  video_page = it.wdata[7:4];
          bmig_pkg::DEV_BANK:   bank_sel[port[1:0]] = it.wdata;
          bmig_pkg::DEV_MISC: begin
            if (misc_ctrl[6] && !it.wdata[6]) irq_status &= ~bmig_pkg::IRQ_MISC_BIT;
            misc_ctrl = it.wdata;
          end
          bmig_pkg::DEV_PRINT:  print_latch = it.wdata;
          bmig_pkg::DEV_IRQ_EN: irq_enable = it.wdata;
          bmig_pkg::DEV_POWER: begin
            if (!it.wdata[0]) powered_down = 1'b1;
          end
          bmig_pkg::DEV_IRQ_ST: irq_status |= ~it.wdata;
          default: ;
        endcase
      end
      bmig_pkg::OP_TICK: irq_status &= ~bmig_pkg::IRQ_KEY_BIT;
      default: ;
    endcase
    r.int_request = |(~irq_status[3:0] & irq_enable[3:0]);
    r.power_off = powered_down;
    r.video_base = video_page;
    r.printer_data = print_latch;
    return r;
  endfunction

  function automatic void check_field(string name, logic [19:0] want, logic [19:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    bmig_pkg::bmig_out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t ns: result with no transaction pending, expected none, got %h",
                   $time, out_data);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("target", 20'(want.target), 20'(out_data.target));
          check_field("phys_addr", want.phys_addr, out_data.phys_addr);
          check_field("read_data", 20'(want.read_data), 20'(out_data.read_data));
          check_field("int_request", 20'(want.int_request), 20'(out_data.int_request));
          check_field("power_off", 20'(want.power_off), 20'(out_data.power_off));
          check_field("video_base", 20'(want.video_base), 20'(out_data.video_base));
          check_field("printer_data", 20'(want.printer_data), 20'(out_data.printer_data));
          results_checked++;
        end
      end
      if (in_valid && in_ready) expected_results.push_back(glue_predict(in_data));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bmig_pkg::CFG_ROM_MASK:  rom_bank_bits = cfg_data[4:0];
          bmig_pkg::CFG_RAM_MASK:  ram_bank_bits = cfg_data[2:0];
          bmig_pkg::CFG_CARD_SIZE: card_bytes = cfg_data;
          default: ;
        endcase
      end
    end
  end

  task automatic bus_access(logic [2:0] op, logic [15:0] addr, logic [7:0] wdata,
                            logic [7:0] keys);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_data = '{op: op, addr: addr, wdata: wdata, key_sense: keys};
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    accesses_sent++;
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [20:0] value);
    wait_idle();
    cfg_index = idx;
    cfg_data = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    reg_writes++;
  endtask

  task automatic test_io_ports();
    bus_access(bmig_pkg::OP_MEM_RD, 16'h0000, 8'h00, 8'h00);
    bus_access(bmig_pkg::OP_MEM_WR, 16'h3FFF, 8'hFF, 8'hFF);
    bus_access(bmig_pkg::OP_IO_WR, 16'hFF11, 8'h41, 8'h00);
    bus_access(bmig_pkg::OP_IO_WR, 16'h0012, 8'hBF, 8'h00);
    bus_access(bmig_pkg::OP_IO_WR, 16'h0013, 8'hC0, 8'h00);
    bus_access(bmig_pkg::OP_IO_RD, 16'h0012, 8'h00, 8'h00);
    bus_access(bmig_pkg::OP_MEM_WR, 16'h7FFF, 8'h00, 8'h00);
    bus_access(bmig_pkg::OP_MEM_RD, 16'hBFFF, 8'h00, 8'h00);
    bus_access(bmig_pkg::OP_MEM_RD, 16'hFFFF, 8'h00, 8'h00);
    bus_access(bmig_pkg::OP_IO_RD, 16'h00A0, 8'h00, 8'h00);
    bus_access(bmig_pkg::OP_IO_WR, 16'h0060, 8'hFF, 8'h00);
    bus_access(bmig_pkg::OP_IO_WR, 16'h0030, 8'h00, 8'h00);
    bus_access(bmig_pkg::OP_IO_RD, 16'h0090, 8'h00, 8'h00);
    bus_access(bmig_pkg::OP_TICK, 16'h0000, 8'h00, 8'h00);
    bus_access(bmig_pkg::OP_IO_RD, 16'h00B9, 8'h00, 8'hA5);
    bus_access(bmig_pkg::OP_IO_RD, 16'h00B0, 8'h00, 8'hFF);
    bus_access(bmig_pkg::OP_IO_RD, 16'h00BA, 8'h00, 8'h5A);
    bus_access(bmig_pkg::OP_IO_WR, 16'h009F, 8'h00, 8'h00);
    bus_access(bmig_pkg::OP_IO_RD, 16'h00C1, 8'h00, 8'h00);
    bus_access(bmig_pkg::OP_IO_RD, 16'h00CE, 8'h00, 8'h00);
    bus_access(bmig_pkg::OP_IO_RD, {8'h00, DEV_CLOCK, 4'h3}, 8'h00, 8'h00);
    bus_access(bmig_pkg::OP_IO_WR, {8'h00, DEV_CLOCK, 4'h3}, 8'h55, 8'h00);
    bus_access(bmig_pkg::OP_IO_WR, 16'h000F, 8'hF0, 8'h00);
    bus_access(bmig_pkg::OP_IO_WR, 16'h0045, 8'hFF, 8'h00);
    bus_access(OP_FIRST_UNUSED, 16'hFFFF, 8'hFF, 8'hFF);
    bus_access(OP_LAST_UNUSED, 16'h0000, 8'h00, 8'h00);
    bus_access(bmig_pkg::OP_IO_WR, 16'h0070, 8'h01, 8'h00);
    bus_access(bmig_pkg::OP_IO_WR, 16'h0070, 8'hFE, 8'h00);
  endtask

  task automatic test_bank_config();
    bus_access(bmig_pkg::OP_IO_WR, 16'h0030, 8'h80, 8'h00);
    write_reg(bmig_pkg::CFG_CARD_SIZE, 21'h100000);
    bus_access(bmig_pkg::OP_MEM_RD, 16'hBFFF, 8'h00, 8'h00);
    bus_access(bmig_pkg::OP_IO_RD, 16'h00A0, 8'h00, 8'h00);
    bus_access(bmig_pkg::OP_IO_WR, 16'h0012, 8'h80, 8'h00);
    write_reg(bmig_pkg::CFG_CARD_SIZE, 21'd1);
    bus_access(bmig_pkg::OP_MEM_RD, 16'h8000, 8'h00, 8'h00);
    bus_access(bmig_pkg::OP_MEM_WR, 16'h8001, 8'h00, 8'h00);
    bus_access(bmig_pkg::OP_IO_WR, 16'h0030, 8'h40, 8'h00);
    bus_access(bmig_pkg::OP_MEM_RD, 16'h8000, 8'h00, 8'h00);
    bus_access(bmig_pkg::OP_IO_WR, 16'h0010, 8'h1F, 8'h00);
    write_reg(bmig_pkg::CFG_ROM_MASK, 21'd31);
    bus_access(bmig_pkg::OP_MEM_RD, 16'h3FFF, 8'h00, 8'h00);
    write_reg(bmig_pkg::CFG_ROM_MASK, 21'd0);
    bus_access(bmig_pkg::OP_MEM_RD, 16'h3FFF, 8'h00, 8'h00);
    bus_access(bmig_pkg::OP_IO_WR, 16'h0011, 8'h47, 8'h00);
    write_reg(bmig_pkg::CFG_RAM_MASK, 21'd7);
    bus_access(bmig_pkg::OP_MEM_WR, 16'h4000, 8'h00, 8'h00);
    write_reg(bmig_pkg::CFG_RAM_MASK, 21'd0);
    bus_access(bmig_pkg::OP_MEM_RD, 16'h7FFF, 8'h00, 8'h00);
  endtask

  task automatic random_settings();
    int unsigned pick;
    pick = $urandom_range(3);
    write_reg(bmig_pkg::CFG_ROM_MASK,
              (pick == 0) ? 21'd0 : (pick == 1) ? 21'd31 : 21'($urandom_range(31)));
    pick = $urandom_range(3);
    write_reg(bmig_pkg::CFG_RAM_MASK,
              (pick == 0) ? 21'd0 : (pick == 1) ? 21'd7 : 21'($urandom_range(7)));
    pick = $urandom_range(4);
    case (pick)
      0:       write_reg(bmig_pkg::CFG_CARD_SIZE, 21'd0);
      1:       write_reg(bmig_pkg::CFG_CARD_SIZE, 21'h100000);
      2:       write_reg(bmig_pkg::CFG_CARD_SIZE, 21'($urandom_range(64, 1) * 16384));
      default: write_reg(bmig_pkg::CFG_CARD_SIZE, 21'($urandom_range(21'h100000, 1)));
    endcase
  endtask

  task automatic random_access();
    int unsigned pick;
    logic [2:0]  op;
    logic [15:0] addr;
    logic [3:0]  dev;
    pick = $urandom_range(99);
    dev = ($urandom_range(99) < 35) ? bmig_pkg::DEV_BANK : 4'($urandom_range(15));
    addr = {8'($urandom_range(255)), dev, 4'($urandom_range(15))};
    if (pick < 40) begin
      op = pick[0] ? bmig_pkg::OP_MEM_WR : bmig_pkg::OP_MEM_RD;
      addr = 16'($urandom_range(65535));
    end else if (pick < 65) begin
      op = bmig_pkg::OP_IO_WR;
    end else if (pick < 90) begin
      op = bmig_pkg::OP_IO_RD;
    end else if (pick < 97) begin
      op = bmig_pkg::OP_TICK;
    end else begin
      op = OP_FIRST_UNUSED + 3'($urandom_range(2));
    end
    bus_access(op, addr, 8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  task automatic test_random_bus(int unsigned send_pct, int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int chunk = 0; chunk < 4; chunk++) begin
      random_settings();
      for (int i = 0; i < 52; i++) random_access();
    end
  endtask

  initial begin
    logic_unused_guard = 1'b0;
    bank_sel = '{default: 8'h00};
    irq_status = bmig_pkg::IRQ_STATUS_RST;
    irq_enable = 8'h00;
    misc_ctrl = 8'hFF;
    video_page = 4'h0;
    print_latch = 8'h00;
    powered_down = 1'b0;
    rom_bank_bits = bmig_pkg::ROM_MASK_RST;
    ram_bank_bits = bmig_pkg::RAM_MASK_RST;
    card_bytes = bmig_pkg::CARD_SIZE_RST;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = bmig_pkg::CFG_ROM_MASK;
    cfg_data = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    test_io_ports();
    test_bank_config();
    test_random_bus(33, 81);
    test_random_bus(81, 33);
    test_random_bus(0, 0);
    wait_idle();

    $display("Sent %0d bus transactions (port and bank checks, then random traffic under",
             accesses_sent);
    $display("three idling mixes); %0d results checked, %0d register writes, %0d mismatches.",
             results_checked, reg_writes, mismatches);
    if (mismatches == 0 && expected_results.size() == 0 && !logic_unused_guard) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

### filelist.f
design/bmig_pkg.sv
design/bmig_xlate.sv
design/bmig_io.sv
design/bank_mapper_io_glue.sv
tb/bank_mapper_io_glue_test.sv
